// ===== design/fpls_pkg.sv =====
// Shared types and constants of the fixed-point line stepper.
`default_nettype none
package fpls_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_BITS    = 32;
  localparam int MAJ_BITS    = COORD_BITS + 1;
  localparam int MINOR_BITS  = ACC_BITS - FRAC_BITS;
  localparam int COLOR_BITS  = 24;
  localparam int SCR_BITS    = 12;
  localparam int QUO_BITS    = FRAC_BITS + 1;
  localparam int CNT_BITS    = $clog2(FRAC_BITS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_BITS = 1;

  localparam logic [SCR_BITS-1:0] SCREEN_WIDTH_RST  = SCR_BITS'(640);
  localparam logic [SCR_BITS-1:0] SCREEN_HEIGHT_RST = SCR_BITS'(480);

  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

  typedef enum logic [0:0] {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } back_state_e;

  // One classified command as it sits in the queue.
  typedef struct packed {
    cmd_e                          cmd;
    logic                          y_major;
    logic                          descending;
    logic                          neg_step;
    logic signed [COORD_BITS-1:0]  major_start;
    logic signed [COORD_BITS-1:0]  major_stop;
    logic signed [COORD_BITS-1:0]  minor_start;
    logic [COORD_BITS-1:0]         short_mag;
    logic [COORD_BITS-1:0]         long_mag;
    logic [COLOR_BITS-1:0]         color;
  } job_t;

endpackage
`default_nettype wire

// ===== design/fpls_front.sv =====
// Front end: classifies an incoming command and works out the line geometry.
`default_nettype none
module fpls_front (
  input  logic                                   cmd_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0] end_y_i,
  input  logic [fpls_pkg::COLOR_BITS-1:0]        line_color_i,
  output fpls_pkg::job_t                         job_o
);

  logic [fpls_pkg::MAJ_BITS-1:0]   dx, dy, short_d, long_d;
  logic [fpls_pkg::MAJ_BITS-1:0]   dx_neg, dy_neg;
  logic [fpls_pkg::COORD_BITS-1:0] adx, ady;
  logic                            y_major;

  always_comb begin
    dx = {end_x_i[fpls_pkg::COORD_BITS-1], end_x_i} -
         {start_x_i[fpls_pkg::COORD_BITS-1], start_x_i};
    dy = {end_y_i[fpls_pkg::COORD_BITS-1], end_y_i} -
         {start_y_i[fpls_pkg::COORD_BITS-1], start_y_i};
    dx_neg = -dx;
    dy_neg = -dy;
    adx = dx[fpls_pkg::MAJ_BITS-1] ? dx_neg[fpls_pkg::COORD_BITS-1:0]
                                   : dx[fpls_pkg::COORD_BITS-1:0];
    ady = dy[fpls_pkg::MAJ_BITS-1] ? dy_neg[fpls_pkg::COORD_BITS-1:0]
                                   : dy[fpls_pkg::COORD_BITS-1:0];
    y_major = ady > adx;
    short_d = y_major ? dx : dy;
    long_d  = y_major ? dy : dx;

    job_o.cmd         = fpls_pkg::cmd_e'(cmd_i);
    job_o.y_major     = y_major;
    job_o.descending  = long_d[fpls_pkg::MAJ_BITS-1] || (long_d == '0);
    job_o.neg_step    = short_d[fpls_pkg::MAJ_BITS-1] ^ long_d[fpls_pkg::MAJ_BITS-1];
    job_o.major_start = y_major ? start_y_i : start_x_i;
    job_o.major_stop  = y_major ? end_y_i : end_x_i;
    job_o.minor_start = y_major ? start_x_i : start_y_i;
    job_o.short_mag   = y_major ? adx : ady;
    job_o.long_mag    = y_major ? ady : adx;
    job_o.color       = line_color_i;
  end

endmodule
`default_nettype wire

// ===== design/fpls_queue.sv =====
// Short command queue between the front end and the stepping engine.
`default_nettype none
module fpls_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpls_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  output fpls_pkg::job_t job_o,
  input  logic           pop_i
);

  fpls_pkg::job_t                     entry_q [fpls_pkg::QUEUE_DEPTH];
  logic [fpls_pkg::QPTR_BITS-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [fpls_pkg::QCNT_BITS-1:0]     count_q, count_d;

  assign full_o  = (count_q == fpls_pkg::QCNT_BITS'(fpls_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == fpls_pkg::QPTR_BITS'(fpls_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == fpls_pkg::QPTR_BITS'(fpls_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/fpls_back.sv =====
// Stepping engine: step divider at line start, DDA walk and pixel output register.
`default_nettype none
module fpls_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   job_valid_i,
  input  fpls_pkg::job_t                         job_i,
  output logic                                   job_pop_o,
  input  logic [fpls_pkg::SCR_BITS-1:0]          screen_width_i,
  input  logic [fpls_pkg::SCR_BITS-1:0]          screen_height_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [fpls_pkg::COORD_BITS-1:0] pixel_x_o,
  output logic signed [fpls_pkg::COORD_BITS-1:0] pixel_y_o,
  output logic [fpls_pkg::COLOR_BITS-1:0]        pixel_color_o,
  output logic                                   on_screen_o,
  output logic                                   last_pixel_o
);

  localparam int CB = fpls_pkg::COORD_BITS;
  localparam int MB = fpls_pkg::MAJ_BITS;
  localparam int NB = fpls_pkg::MINOR_BITS;
  localparam int AB = fpls_pkg::ACC_BITS;
  localparam int QB = fpls_pkg::QUO_BITS;

  fpls_pkg::back_state_e state_q, state_d;
  logic                  line_active_q, line_active_d;
  logic                  out_valid_q, out_valid_d;
  logic [fpls_pkg::CNT_BITS-1:0] cnt_q, cnt_d;

  // Line state (no reset needed: gated by line_active_q)
  logic                  y_major_q, descending_q, neg_q;
  logic [MB-1:0]         pos_q, pos_d, end_q;
  logic [AB-1:0]         acc_q, acc_d, step_q, step_d;
  logic [fpls_pkg::COLOR_BITS-1:0] color_q;
  logic [CB-1:0]         div_q, rem_q, rem_d;
  logic [QB-1:0]         quo_q, quo_d;

  // Output payload
  logic [CB-1:0]         px_q, py_q;
  logic [fpls_pkg::COLOR_BITS-1:0] pcol_q;
  logic                  vis_q, last_q;

  logic                  out_free, take, start, emit, div_last;
  logic [CB:0]           rem_sh, rem_sub;
  logic                  ge;
  logic [QB-1:0]         quo_mag;
  logic [AB-1:0]         step_mag;
  logic [NB-1:0]         minor, pos_ext, px_full, py_full;
  logic                  vis, last;
  logic                  int_ge;

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    take  = (state_q == fpls_pkg::ST_RUN) && job_valid_i &&
            ((job_i.cmd == fpls_pkg::CMD_START) || !line_active_q || out_free);
    start = take && (job_i.cmd == fpls_pkg::CMD_START);
    emit  = take && (job_i.cmd == fpls_pkg::CMD_ADVANCE) && line_active_q;

    // one fractional quotient bit per cycle
    rem_sh  = {rem_q, 1'b0};
    ge      = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
    div_last = (state_q == fpls_pkg::ST_DIV) && (cnt_q == fpls_pkg::CNT_BITS'(1));
    quo_mag  = (div_q == '0) ? '0 : {quo_q[QB-2:0], ge};
    step_mag = {{(AB-QB){1'b0}}, quo_mag};

    // pixel at the current position
    minor   = acc_q[AB-1 -: NB];
    pos_ext = {{(NB-MB){pos_q[MB-1]}}, pos_q};
    px_full = y_major_q ? minor : pos_ext;
    py_full = y_major_q ? pos_ext : minor;
    vis = !px_full[NB-1] && (px_full[NB-2:0] < {{(NB-1-fpls_pkg::SCR_BITS){1'b0}}, screen_width_i})
       && !py_full[NB-1] && (py_full[NB-2:0] < {{(NB-1-fpls_pkg::SCR_BITS){1'b0}}, screen_height_i});
    last = (pos_q == end_q);

    int_ge = job_i.short_mag >= job_i.long_mag;

    state_d       = state_q;
    line_active_d = line_active_q;
    cnt_d         = cnt_q;
    pos_d         = pos_q;
    acc_d         = acc_q;
    step_d        = step_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    out_valid_d   = out_valid_q && out_stall_i;

    unique case (state_q)
      fpls_pkg::ST_RUN: begin
        if (start) begin
          state_d       = fpls_pkg::ST_DIV;
          line_active_d = 1'b1;
          cnt_d         = fpls_pkg::CNT_BITS'(fpls_pkg::FRAC_BITS);
          pos_d         = {job_i.major_start[CB-1], job_i.major_start};
          acc_d         = {{(NB-CB){job_i.minor_start[CB-1]}}, job_i.minor_start,
                           1'b1, {(fpls_pkg::FRAC_BITS-1){1'b0}}};
          // integer quotient bit: short magnitude never exceeds long magnitude
          quo_d         = {{(QB-1){1'b0}}, int_ge};
          rem_d         = int_ge ? job_i.short_mag - job_i.long_mag : job_i.short_mag;
        end else if (emit) begin
          out_valid_d   = 1'b1;
          pos_d         = descending_q ? pos_q - 1'b1 : pos_q + 1'b1;
          acc_d         = descending_q ? acc_q - step_q : acc_q + step_q;
          line_active_d = !last;
        end
      end
      fpls_pkg::ST_DIV: begin
        rem_d = ge ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
        quo_d = {quo_q[QB-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (div_last) begin
          state_d = fpls_pkg::ST_RUN;
          step_d  = neg_q ? -step_mag : step_mag;
        end
      end
      default: state_d = fpls_pkg::ST_RUN;
    endcase
  end

  assign job_pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fpls_pkg::ST_RUN;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
    end else begin
      state_q       <= state_d;
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    acc_q  <= acc_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    if (start) begin
      y_major_q    <= job_i.y_major;
      descending_q <= job_i.descending;
      neg_q        <= job_i.neg_step;
      end_q        <= {job_i.major_stop[CB-1], job_i.major_stop};
      color_q      <= job_i.color;
      div_q        <= job_i.long_mag;
    end
    if (emit) begin
      px_q   <= px_full[CB-1:0];
      py_q   <= py_full[CB-1:0];
      pcol_q <= color_q;
      vis_q  <= vis;
      last_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign on_screen_o   = vis_q;
  assign last_pixel_o  = last_q;

endmodule
`default_nettype wire

// ===== design/fixed_point_line_stepper.sv =====
// Fixed-point DDA line stepper, top level.
//
// Input channel (in_valid_i / in_stall_o): a transaction with cmd_i = start
// loads two signed endpoints and a color; cmd_i = advance asks for the next
// pixel of the current line. Commands land in a two-entry queue, so the
// input side only stalls when that queue is full.
// Output channel (out_valid_o / out_stall_i): one pixel transaction per
// advance on an active line, with on_screen_o and last_pixel_o flags.
// Advances on an idle line and start commands produce no output.
// One pixel per cycle while advances stream in and the output is not stalled.
// A start command occupies the engine while the step divider produces one
// quotient bit per cycle. An accepted advance passes the queue entry, then
// the pixel output register. A stalled output holds its pixel; the engine
// stops at the next advance that would make a pixel, the queue fills behind
// it and in_stall_o rises. Reset empties the queue, ends any line and loads
// the screen size 640 x 480. Configuration (cfg_we_i, cfg_index_i, cfg_data_i)
// must be written by the user only while idle; the block does not enforce it.
`default_nettype none
module fixed_point_line_stepper (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [fpls_pkg::CFG_IDX_BITS-1:0]          cfg_index_i,
  input  logic [fpls_pkg::SCR_BITS-1:0]              cfg_data_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic                                       cmd_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0]     start_x_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0]     start_y_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0]     end_x_i,
  input  logic signed [fpls_pkg::COORD_BITS-1:0]     end_y_i,
  input  logic [fpls_pkg::COLOR_BITS-1:0]            line_color_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [fpls_pkg::COORD_BITS-1:0]     pixel_x_o,
  output logic signed [fpls_pkg::COORD_BITS-1:0]     pixel_y_o,
  output logic [fpls_pkg::COLOR_BITS-1:0]            pixel_color_o,
  output logic                                       on_screen_o,
  output logic                                       last_pixel_o
);

  logic [fpls_pkg::SCR_BITS-1:0] screen_width_q, screen_height_q;
  fpls_pkg::job_t                front_job, queue_job;
  logic                          queue_full, queue_valid, queue_pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= fpls_pkg::SCREEN_WIDTH_RST;
      screen_height_q <= fpls_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fpls_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        fpls_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign push       = in_valid_i && !queue_full;
  assign in_stall_o = queue_full;

  fpls_front u_front (
    .cmd_i        (cmd_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_color_i (line_color_i),
    .job_o        (front_job)
  );

  fpls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .job_o   (queue_job),
    .pop_i   (queue_pop)
  );

  fpls_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (queue_valid),
    .job_i           (queue_job),
    .job_pop_o       (queue_pop),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .on_screen_o     (on_screen_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-point DDA line stepper.
module tb_top;
  import fpls_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 300;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic                         on_screen;
    logic                         last;
  } pixel_t;

  typedef enum int {
    STALL_OPEN,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE,
    STALL_HOLD
  } stall_mode_e;

  // DDA predictor plus the queue of pixels it still owes.
  class line_pixel_checker;
    logic [SCR_BITS-1:0]         scr_width;
    logic [SCR_BITS-1:0]         scr_height;
    bit                          line_active;
    bit                          y_major;
    bit                          descending;
    logic signed [MAJ_BITS-1:0]  major_pos;
    logic signed [MAJ_BITS-1:0]  major_end;
    logic [ACC_BITS-1:0]         minor_acc;
    logic [ACC_BITS-1:0]         minor_step;
    logic [COLOR_BITS-1:0]       held_color;
    pixel_t                      expected_pixels[$];
    int unsigned                 mismatches;

    function new();
      scr_width   = SCREEN_WIDTH_RST;
      scr_height  = SCREEN_HEIGHT_RST;
      line_active = 1'b0;
      y_major     = 1'b0;
      descending  = 1'b0;
      major_pos   = '0;
      major_end   = '0;
      minor_acc   = '0;
      minor_step  = '0;
      held_color  = '0;
      mismatches  = 0;
    endfunction

    function void set_screen(logic [CFG_IDX_BITS-1:0] idx, logic [SCR_BITS-1:0] value);
      if (idx == REG_SCREEN_WIDTH) begin
        scr_width = value;
      end else begin
        scr_height = value;
      end
    endfunction

    function void note_command(cmd_e cmd, logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                               logic [COLOR_BITS-1:0] color);
      int     dx, dy, short_d, long_d, m_start, mn_start, minor, px, py;
      longint quo;
      pixel_t want;
      if (cmd == CMD_START) begin
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        y_major = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
        if (y_major) begin
          short_d = dx; long_d = dy; m_start = sy; mn_start = sx;
        end else begin
          short_d = dy; long_d = dx; m_start = sx; mn_start = sy;
        end
        // signed longint division truncates toward zero
        quo = (long_d == 0) ? 0 :
              (longint'(short_d) * (longint'(1) << FRAC_BITS)) / longint'(long_d);
        minor_step = ACC_BITS'(quo);
        minor_acc  = ACC_BITS'((longint'(1) << (FRAC_BITS - 1)) +
                               longint'(mn_start) * (longint'(1) << FRAC_BITS));
        descending  = long_d <= 0;
        major_pos   = MAJ_BITS'(m_start);
        major_end   = MAJ_BITS'(m_start + long_d);
        held_color  = color;
        line_active = 1'b1;
      end else if (line_active) begin
        minor = $signed(minor_acc) >>> FRAC_BITS;
        px = y_major ? minor : int'(major_pos);
        py = y_major ? int'(major_pos) : minor;
        want.x         = COORD_BITS'(px);
        want.y         = COORD_BITS'(py);
        want.color     = held_color;
        want.on_screen = px >= 0 && px < int'(scr_width) && py >= 0 && py < int'(scr_height);
        want.last      = major_pos == major_end;
        expected_pixels.push_back(want);
        // accumulator steps on every pixel, clipped or not
        if (descending) begin
          minor_acc = minor_acc - minor_step;
          major_pos = major_pos - 1'b1;
        end else begin
          minor_acc = minor_acc + minor_step;
          major_pos = major_pos + 1'b1;
        end
        if (want.last) line_active = 1'b0;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel x=%0d y=%0d color=%06h on=%0b last=%0b",
                   got.x, got.y, got.color, got.on_screen, got.last);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
          got.on_screen !== want.on_screen || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("pixel mismatch: exp %0d,%0d %06h on=%0b last=%0b got %0d,%0d %06h %0b %0b",
                   want.x, want.y, want.color, want.on_screen, want.last,
                   got.x, got.y, got.color, got.on_screen, got.last);
      end
    endfunction
  endclass

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          cfg_we_i     = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i  = '0;
  logic [SCR_BITS-1:0]           cfg_data_i   = '0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic                          cmd_i        = 1'b0;
  logic signed [COORD_BITS-1:0]  start_x_i    = '0;
  logic signed [COORD_BITS-1:0]  start_y_i    = '0;
  logic signed [COORD_BITS-1:0]  end_x_i      = '0;
  logic signed [COORD_BITS-1:0]  end_y_i      = '0;
  logic [COLOR_BITS-1:0]         line_color_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic signed [COORD_BITS-1:0]  pixel_x_o;
  logic signed [COORD_BITS-1:0]  pixel_y_o;
  logic [COLOR_BITS-1:0]         pixel_color_o;
  logic                          on_screen_o;
  logic                          last_pixel_o;

  line_pixel_checker sb = new();

  int          burst_left  = 0;
  int          hold_asks   = 0;
  int          hold_seen   = 0;
  stall_mode_e stall_mode  = STALL_OPEN;
  int          stall_left  = 0;
  int unsigned cycle_count = 0;

  fixed_point_line_stepper dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // pixels are checked before the same edge's command is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_pixel(pixel_t'{pixel_x_o, pixel_y_o, pixel_color_o, on_screen_o,
                                last_pixel_o});
      if (in_valid_i && !in_stall_o)
        sb.note_command(cmd_e'(cmd_i), start_x_i, start_y_i, end_x_i, end_y_i, line_color_i);
    end
  end

  // receiver back-pressure: random segments, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      if (hold_asks != hold_seen) begin
        hold_seen  = hold_asks;
        stall_mode = STALL_HOLD;
        stall_left = HOLD_CYCLES;
      end else begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(10, 80);
      end
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_OPEN:   out_stall_i <= 1'b0;
      STALL_LIGHT:  out_stall_i <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY:  out_stall_i <= ($urandom_range(0, 4) != 0);
      STALL_TOGGLE: out_stall_i <= ~out_stall_i;
      default:      out_stall_i <= 1'b1;
    endcase
  end

  task automatic send_cmd(input cmd_e cmd, input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                          input logic [COLOR_BITS-1:0] color);
    int gap;
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    start_x_i    <= sx;
    start_y_i    <= sy;
    end_x_i      <= ex;
    end_y_i      <= ey;
    line_color_i <= color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // advance with junk in the endpoint fields, which the block must ignore
  task automatic step_pixel();
    send_cmd(CMD_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
             COORD_BITS'($urandom), COORD_BITS'($urandom), COLOR_BITS'($urandom));
  endtask

  task automatic program_screen(input logic [SCR_BITS-1:0] w, h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SCREEN_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    sb.set_screen(REG_SCREEN_WIDTH, w);
    cfg_index_i <= REG_SCREEN_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    sb.set_screen(REG_SCREEN_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  // let the last transaction be noted, collect every pixel, then let setup work finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord(logic [SCR_BITS-1:0] lim);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return COORD_BITS'(int'($urandom_range(0, int'(lim) + 16)) - 8);
      5, 6:          return COORD_BITS'($urandom);
      7:             return COORD_BITS'(2047);
      8:             return COORD_BITS'(-2048);
      default:       return '0;
    endcase
  endfunction

  task automatic run_directed();
    step_pixel();                                       // advance with no line
    send_cmd(CMD_START, 10, 20, 10, 20, 24'hFFFFFF);    // single point
    step_pixel();
    step_pixel();                                       // idle again after last pixel
    send_cmd(CMD_START, -2048, -2048, 2047, 2047, 24'h000000);
    step_pixel();
    step_pixel();
    send_cmd(CMD_START, 2047, -2048, -2048, 2047, 24'hA5A5A5);  // descending x
    step_pixel();
    send_cmd(CMD_START, 0, 0, 2, -7, 24'h5A5A5A);       // descending y major
    step_pixel();
    step_pixel();
    send_cmd(CMD_START, 0, 5, 3, 5, 24'h123456);        // replaced before any pixel
    send_cmd(CMD_START, 100, -3, 97, 50, 24'hFEDCBA);
    step_pixel();
    step_pixel();
    send_cmd(CMD_START, -1, -1, 1, 3, 24'h0F0F0F);      // crosses the screen corner
    step_pixel();
    step_pixel();
    step_pixel();
    send_cmd(CMD_START, 639, 479, 640, 480, 24'hF0F0F0);  // far screen edge
    step_pixel();
    step_pixel();
  endtask

  task automatic run_lines(input int quota);
    int counted, len, n, dx, dy, d, kind;
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
    counted = 0;
    while (counted < quota) begin
      sx   = pick_coord(sb.scr_width);
      sy   = pick_coord(sb.scr_height);
      d    = int'($urandom_range(0, 30)) - 15;
      kind = $urandom_range(0, 9);
      case (kind)
        6: begin ex = COORD_BITS'(int'(sx) + d); ey = sy; end
        7: begin ex = sx; ey = COORD_BITS'(int'(sy) + d); end
        8: begin ex = COORD_BITS'(int'(sx) + d); ey = COORD_BITS'(int'(sy) - d); end
        9: begin ex = pick_coord(sb.scr_width); ey = pick_coord(sb.scr_height); end
        default: begin
          ex = COORD_BITS'(int'(sx) + int'($urandom_range(0, 24)) - 12);
          ey = COORD_BITS'(int'(sy) + int'($urandom_range(0, 24)) - 12);
        end
      endcase
      dx  = int'(ex) - int'(sx);
      dy  = int'(ey) - int'(sy);
      len = (((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy) ? ((dx < 0) ? -dx : dx)
                                                           : ((dy < 0) ? -dy : dy)) + 1;
      if (len > 64)
        n = $urandom_range(0, 48);
      else if ($urandom_range(0, 3) == 0)
        n = $urandom_range(0, len);                     // may be cut short by the next start
      else
        n = len + $urandom_range(0, 2);                 // may run past the end
      if ($urandom_range(0, 15) == 0) step_pixel();
      send_cmd(CMD_START, sx, sy, ex, ey, COLOR_BITS'($urandom));
      counted++;
      repeat (n) step_pixel();
      counted += (n < len) ? n : len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain();
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: program_screen(12'd1, 12'd1);
        2: program_screen(12'd4095, 12'd4095);
        3: program_screen(12'd0, 12'd0);
        4: program_screen(12'd2048, 12'd1);
        5: program_screen(SCR_BITS'($urandom_range(1, 2047)),
                          SCR_BITS'($urandom_range(1, 2047)));
        default: ;
      endcase
      if (p == 1 || p == 4) hold_asks <= hold_asks + 1;
      run_lines(PHASE_ITEMS);
      drain();
    end
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/fpls_pkg.sv
design/fpls_front.sv
design/fpls_queue.sv
design/fpls_back.sv
design/fixed_point_line_stepper.sv
verif/tb_top.sv
